// File: src/rhs_pkg.sv
// Package for the RGB to HSV saturation pipeline: widths, stage counts and
// the pipeline stage record. No dependencies.
package rhs_pkg;

    localparam int PIX_W     = 8;                 // width of one color sample
    localparam int FRAC_BITS = 15;                // fraction bits of the result, 8..24
    localparam int SAT_W     = 16;                // width of the saturation field
    localparam int QUO_W     = FRAC_BITS + 1;     // full quotient, up to 1.0
    localparam int IN_DATA_W = 3 * PIX_W;         // red, green, blue packed

    // Restoring divider: quotient bits resolved per pipeline stage
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = (FRAC_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    localparam logic [SAT_W-1:0] SAT_MAX = {SAT_W{1'b1}};

    typedef struct packed {
        logic [PIX_W-1:0] hi;     // divisor: largest sample
        logic [PIX_W-1:0] rem;    // partial remainder, below hi unless the pixel is black
        logic [QUO_W-1:0] quo;    // quotient bits resolved so far
        logic             undef;  // black pixel
        logic             eoi;    // end-of-image mark
    } stage_t;

endpackage

// File: src/rgb_hsv_saturation.sv
// Top level: HSV saturation (max - min) / max of an RGB pixel stream.
// Depends on rhs_pkg.
//
//  channel  | dir | tdata                            | tuser      | tlast
//  s_axis   | in  | [7:0] red [15:8] green [23:16] blue | -       | end_of_image
//  m_axis   | out | [15:0] saturation                | undefined  | end_of_image_out
//
// One pixel per clock, sustained while m_axis is ready. The pipeline is one
// stage for max/min and the top quotient bit, DIV_STAGES stages of the
// restoring divider at up to STEPS_PER_STAGE bits each, and one output
// register that saturates and masks black pixels.
// Reset clears only the stage and output valid bits; data registers are not reset.
// A stall at m_axis holds the output; each stage still fills while the one
// ahead of it is empty, so bubbles get squeezed and no request is lost.
module rgb_hsv_saturation
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rhs_pkg::IN_DATA_W-1:0] s_axis_tdata,   // red, green, blue
    input  logic                          s_axis_tlast,   // end_of_image
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rhs_pkg::SAT_W-1:0]     m_axis_tdata,   // saturation
    output logic                          m_axis_tuser,   // undefined
    output logic                          m_axis_tlast    // end_of_image_out
);
    import rhs_pkg::*;

    // Stage 0 is max/min, stages 1..DIV_STAGES run the divider
    stage_t               st_reg  [0:DIV_STAGES];
    stage_t               st_next [0:DIV_STAGES];
    logic [DIV_STAGES:0]  vld_reg;
    logic [DIV_STAGES:0]  adv;

    logic                 out_vld_reg;
    logic [SAT_W-1:0]     out_data_reg;
    logic [SAT_W-1:0]     out_data_next;
    logic                 out_undef_reg;
    logic                 out_eoi_reg;
    logic                 out_adv;

    logic [PIX_W-1:0]     red, green, blue;
    logic [PIX_W-1:0]     hi, lo;

    // ---------------- flow control ----------------
    // A stage takes a new request when empty or when it hands its own on.
    assign out_adv = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        adv[DIV_STAGES] = !vld_reg[DIV_STAGES] || out_adv;
        for (int i = DIV_STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[0];

    // ---------------- stage 0: max, min, top quotient bit ----------------
    assign red   = s_axis_tdata[PIX_W-1:0];
    assign green = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign blue  = s_axis_tdata[3*PIX_W-1:2*PIX_W];

    always_comb
    begin
        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue  > hi) hi = blue;
        if (green < lo) lo = green;
        if (blue  < lo) lo = blue;

        // diff <= hi, so the integer bit is set only when min is zero;
        // then the ratio is exactly 1.0 and nothing remains.
        st_next[0].hi    = hi;
        st_next[0].undef = (hi == '0);
        st_next[0].eoi   = s_axis_tlast;
        if (lo == '0)
        begin
            st_next[0].rem = '0;
            st_next[0].quo = QUO_W'(1);
        end
        else
        begin
            st_next[0].rem = hi - lo;
            st_next[0].quo = '0;
        end
    end

    // ---------------- divider stages ----------------
    genvar g;
    generate
        for (g = 1; g <= DIV_STAGES; g++)
        begin : g_div
            always_comb
            begin
                logic [PIX_W:0]   trial;
                logic [PIX_W-1:0] rem;
                logic [QUO_W-1:0] quo;
                logic             qbit;
                rem = st_reg[g-1].rem;
                quo = st_reg[g-1].quo;
                for (int k = 0; k < STEPS_PER_STAGE; k++)
                begin
                    if ((g - 1) * STEPS_PER_STAGE + k < FRAC_BITS)
                    begin
                        trial = {rem, 1'b0};
                        qbit  = (trial >= {1'b0, st_reg[g-1].hi});
                        if (qbit)
                        begin
                            trial = trial - {1'b0, st_reg[g-1].hi};
                        end
                        rem = trial[PIX_W-1:0];
                        quo = {quo[QUO_W-2:0], qbit};
                    end
                end
                st_next[g]     = st_reg[g-1];
                st_next[g].rem = rem;
                st_next[g].quo = quo;
            end
        end
    endgenerate

    // ---------------- output: clamp and mask ----------------
    generate
        if (QUO_W > SAT_W)
        begin : g_clamp
            always_comb
            begin
                if (st_reg[DIV_STAGES].undef)
                    out_data_next = '0;
                else if (|st_reg[DIV_STAGES].quo[QUO_W-1:SAT_W])
                    out_data_next = SAT_MAX;
                else
                    out_data_next = st_reg[DIV_STAGES].quo[SAT_W-1:0];
            end
        end
        else
        begin : g_noclamp
            always_comb
            begin
                if (st_reg[DIV_STAGES].undef)
                    out_data_next = '0;
                else
                    out_data_next = SAT_W'(st_reg[DIV_STAGES].quo);
            end
        end
    endgenerate

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
            if (out_adv)
                out_vld_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= DIV_STAGES; i++)
        begin
            if (adv[i])
                st_reg[i] <= st_next[i];
        end
        if (out_adv)
        begin
            out_data_reg  <= out_data_next;
            out_undef_reg <= st_reg[DIV_STAGES].undef;
            out_eoi_reg   <= st_reg[DIV_STAGES].eoi;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_undef_reg;
    assign m_axis_tlast  = out_eoi_reg;

`ifndef ASSERT_OFF
    // Black pixel always comes out as zero saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("undefined result with nonzero saturation");

    // Divider invariant: remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STAGES] && !st_reg[DIV_STAGES].undef |->
        st_reg[DIV_STAGES].rem < st_reg[DIV_STAGES].hi)
        else $error("divider remainder not below divisor");

    // With the output empty every stage can move, so input must be ready
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A held output request is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("stalled result changed");
`endif

endmodule
